// ===== src/eqvr_pkg.sv =====
package eqvr_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int ATAN_COUNT       = 30;

  // pi/180 scaled by 2^32, and the CORDIC limit gain in Q30
  localparam logic [26:0] DEG_TO_RAD_Q32  = 27'd74961321;
  localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032874;

  localparam int WIDE_W = 72;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  function automatic logic [29:0] atan_q30(int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'd843314856;
      1:  a = 30'd497837829;
      2:  a = 30'd263043836;
      3:  a = 30'd133525158;
      4:  a = 30'd67021686;
      5:  a = 30'd33543515;
      6:  a = 30'd16775850;
      7:  a = 30'd8388437;
      8:  a = 30'd4194282;
      9:  a = 30'd2097149;
      default: a = 30'd1 << (30 - i);
    endcase
    return a;
  endfunction

  // add half an LSB, then arithmetic shift
  function automatic wide_t rnd_shift(wide_t v, int s);
    return (v + (wide_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    logic signed [31:0] r;
    if (v > wide_t'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < wide_t'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/eqvr_if.sv =====
interface eqvr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] angle_x;
  logic signed [31:0] angle_y;
  logic signed [31:0] angle_z;

  modport source (output valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                output ready);
endinterface

interface eqvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== src/eqvr_half_sincos.sv =====
module eqvr_half_sincos
  import eqvr_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ang,
  output logic signed [32:0] sin_half,
  output logic signed [32:0] cos_half
);

  localparam int N     = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam longint OFF = 360 * (((64'sd1 <<< (31 - FRAC_BITS)) + 359) / 360);
  localparam int UW    = $clog2(2 * OFF) + 1;
  localparam int SH    = UW + 9;
  localparam int QW    = UW - 8;
  localparam int PW    = 2 * UW + 1;
  localparam logic [UW:0] RECIP = (UW + 1)'((64'sd1 <<< SH) / 360);
  localparam int RW    = FRAC_BITS + 9;
  localparam int TW    = FRAC_BITS + 8;
  localparam int SW    = FRAC_BITS + 36;
  localparam logic [RW-1:0] HALF_TURN = RW'(180) << FRAC_BITS;
  localparam logic [RW-1:0] FULL_TURN = RW'(360) << FRAC_BITS;

  // stage A: whole degrees made nonnegative by a multiple of 360
  logic signed [32:0]     deg_in;
  logic [UW-1:0]          u_a, u_b;
  logic [FRAC_BITS-1:0]   frac_a, frac_b;
  logic [PW-1:0]          prod;
  logic [QW-1:0]          q_b;
  logic [UW-1:0]          qm, rem;
  logic [8:0]             deg_c;
  logic [RW-1:0]          r_c;
  logic [TW-1:0]          t_d;
  logic                   flip_d, flip_e;
  logic [34:0]            pa_e;
  logic [FRAC_BITS+26:0]  pb_e;
  logic [SW-1:0]          zsum;
  logic signed [33:0]     cx [0:N];
  logic signed [33:0]     cy [0:N];
  logic signed [33:0]     cz [0:N];
  logic                   flp [0:N];

  assign deg_in = $signed({ang[31], ang}) >>> FRAC_BITS;
  assign prod   = PW'(u_a) * PW'(RECIP);
  assign qm     = UW'(q_b) * UW'(360);
  assign rem    = u_b - qm;
  assign deg_c  = (rem >= UW'(360)) ? 9'(rem - UW'(360)) : 9'(rem);
  assign zsum   = (SW'(pa_e) << FRAC_BITS) + SW'(pb_e) + (SW'(1) << (FRAC_BITS + 2));

  always_ff @(posedge clk) begin
    if (en) begin
      u_a    <= UW'(deg_in + 33'(OFF));
      frac_a <= ang[FRAC_BITS-1:0];
      q_b    <= QW'(prod >> SH);
      u_b    <= u_a;
      frac_b <= frac_a;
      r_c    <= {deg_c, frac_b};
      flip_d <= r_c > HALF_TURN;
      t_d    <= (r_c > HALF_TURN) ? TW'(FULL_TURN - r_c) : TW'(r_c);
      pa_e   <= 35'(t_d[TW-1:FRAC_BITS]) * 35'(DEG_TO_RAD_Q32);
      pb_e   <= (FRAC_BITS + 27)'(t_d[FRAC_BITS-1:0]) * (FRAC_BITS + 27)'(DEG_TO_RAD_Q32);
      flip_e <= flip_d;
      cx[0]  <= 34'(CORDIC_GAIN_Q30);
      cy[0]  <= '0;
      cz[0]  <= 34'(zsum >> (FRAC_BITS + 3));
      flp[0] <= flip_e;
      sin_half <= 33'(cy[N]);
      cos_half <= flp[N] ? -33'(cx[N]) : 33'(cx[N]);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed(34'(atan_q30(i)));
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed(34'(atan_q30(i)));
        end
        flp[i+1] <= flp[i];
      end
    end
  end

endmodule

// ===== src/euler_quaternion_vector_rotation_unit.sv =====
// Rotates a vector by three Euler angles through a unit quaternion.
// Input channel inp carries vec_x/y/z (signed Q16.16) and angle_x/y/z
// (signed Q16.16 degrees); output channel res carries out_x/y/z, the
// rotated vector in the vector's format, saturated to 32 bits.
// A transaction happens on a rising clk edge with valid and ready high.
// Each transaction gives exactly one result, in order.
// Pipeline: seven stages for angle reduction, radian scaling and sin/cos
// output, one stage per CORDIC step, and nine for the two quaternion
// products, the vector products and saturation.
// Throughput: one transaction per cycle while res is not stalled; every
// stage is a register step with a valid bit, and the whole pipeline
// advances together.
// When res is stalled with a result waiting, every stage holds and inp.ready
// drops; no data is lost or repeated. Only the last stage decides ready, so
// bubbles further up are not squeezed out during a stall.
// Reset (rst, synchronous) clears all valid bits; data registers are not
// cleared and the pipe is empty in the cycle after reset.
module euler_quaternion_vector_rotation_unit
  import eqvr_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic       clk,
  input logic       rst,
  eqvr_in_if.sink   inp,
  eqvr_out_if.source res
);

  localparam int N      = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
  localparam int LAT_SC = N + 7;
  localparam int LAT    = LAT_SC + 9;
  localparam int VD     = LAT_SC + 4;

  logic               en;
  logic [LAT-1:0]     vld;
  vec_t               vd [0:VD-1];
  logic signed [32:0] sx, cx, sy, cy, sz, cz;
  logic signed [32:0] sz_m1, cz_m1, sz_m2, cz_m2;
  wide_t              mp [0:3];
  logic signed [32:0] m [0:3];
  wide_t              qp [0:7];
  logic signed [31:0] q [0:3];
  logic signed [31:0] q_p1 [0:3];
  logic signed [31:0] q_p2 [0:3];
  wide_t              pp [0:11];
  logic signed [35:0] p [0:3];
  wide_t              rp [0:11];
  logic signed [43:0] r [0:2];
  logic signed [31:0] ox, oy, oz;

  assign en        = !vld[LAT-1] || res.ready;
  assign inp.ready = en;
  assign res.valid = vld[LAT-1];
  assign res.out_x = ox;
  assign res.out_y = oy;
  assign res.out_z = oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], inp.valid};
    end
  end

  eqvr_half_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_x (
    .clk(clk), .en(en), .ang(inp.angle_x), .sin_half(sx), .cos_half(cx)
  );
  eqvr_half_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_y (
    .clk(clk), .en(en), .ang(inp.angle_y), .sin_half(sy), .cos_half(cy)
  );
  eqvr_half_sincos #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_sc_z (
    .clk(clk), .en(en), .ang(inp.angle_z), .sin_half(sz), .cos_half(cz)
  );

  // vector waits alongside the angle path until the rotation is known
  always_ff @(posedge clk) begin
    if (en) begin
      vd[0] <= '{x: inp.vec_x, y: inp.vec_y, z: inp.vec_z};
      for (int k = 1; k < VD; k++) begin
        vd[k] <= vd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // qy * qx
      mp[0] <= cy * sx;
      mp[1] <= sy * cx;
      mp[2] <= sy * sx;
      mp[3] <= cy * cx;
      sz_m1 <= sz;
      cz_m1 <= cz;
      m[0]  <= 33'(rnd_shift(mp[0], 30));
      m[1]  <= 33'(rnd_shift(mp[1], 30));
      m[2]  <= 33'(rnd_shift(-mp[2], 30));
      m[3]  <= 33'(rnd_shift(mp[3], 30));
      sz_m2 <= sz_m1;
      cz_m2 <= cz_m1;
      // (qy * qx) * qz
      qp[0] <= m[0] * cz_m2;
      qp[1] <= m[1] * sz_m2;
      qp[2] <= m[0] * sz_m2;
      qp[3] <= m[1] * cz_m2;
      qp[4] <= m[3] * sz_m2;
      qp[5] <= m[2] * cz_m2;
      qp[6] <= m[3] * cz_m2;
      qp[7] <= m[2] * sz_m2;
      q[0]  <= 32'(rnd_shift(rnd_shift(qp[0] + qp[1], 30), 2));
      q[1]  <= 32'(rnd_shift(rnd_shift(qp[3] - qp[2], 30), 2));
      q[2]  <= 32'(rnd_shift(rnd_shift(qp[4] + qp[5], 30), 2));
      q[3]  <= 32'(rnd_shift(rnd_shift(qp[6] - qp[7], 30), 2));
      // q * v
      pp[0]  <= q[3] * vd[VD-1].x;
      pp[1]  <= q[1] * vd[VD-1].z;
      pp[2]  <= q[2] * vd[VD-1].y;
      pp[3]  <= q[3] * vd[VD-1].y;
      pp[4]  <= q[0] * vd[VD-1].z;
      pp[5]  <= q[2] * vd[VD-1].x;
      pp[6]  <= q[3] * vd[VD-1].z;
      pp[7]  <= q[0] * vd[VD-1].y;
      pp[8]  <= q[1] * vd[VD-1].x;
      pp[9]  <= q[0] * vd[VD-1].x;
      pp[10] <= q[1] * vd[VD-1].y;
      pp[11] <= q[2] * vd[VD-1].z;
      q_p1   <= q;
      p[0]   <= 36'(rnd_shift(pp[0] + pp[1] - pp[2], 28));
      p[1]   <= 36'(rnd_shift(pp[3] - pp[4] + pp[5], 28));
      p[2]   <= 36'(rnd_shift(pp[6] + pp[7] - pp[8], 28));
      p[3]   <= 36'(rnd_shift(-pp[9] - pp[10] - pp[11], 28));
      q_p2   <= q_p1;
      // p * conj(q)
      rp[0]  <= p[3] * q_p2[0];
      rp[1]  <= p[0] * q_p2[3];
      rp[2]  <= p[1] * q_p2[2];
      rp[3]  <= p[2] * q_p2[1];
      rp[4]  <= p[3] * q_p2[1];
      rp[5]  <= p[0] * q_p2[2];
      rp[6]  <= p[1] * q_p2[3];
      rp[7]  <= p[2] * q_p2[0];
      rp[8]  <= p[3] * q_p2[2];
      rp[9]  <= p[0] * q_p2[1];
      rp[10] <= p[1] * q_p2[0];
      rp[11] <= p[2] * q_p2[3];
      r[0]   <= 44'(rnd_shift(rp[1] - rp[0] - rp[2] + rp[3], 28));
      r[1]   <= 44'(rnd_shift(rp[5] - rp[4] + rp[6] - rp[7], 28));
      r[2]   <= 44'(rnd_shift(rp[10] - rp[8] - rp[9] + rp[11], 28));
      ox     <= sat32(wide_t'(r[0]));
      oy     <= sat32(wide_t'(r[1]));
      oz     <= sat32(wide_t'(r[2]));
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (inp.valid && inp.ready) |=> vld[0])
    else $error("accepted transaction did not enter the pipeline");

endmodule
